// File: sv/nsht_pkg.sv
// ----------------------------------------------------------------------------
// nsht_pkg
// Widths, reset values and defaults shared by the nearest segment hit test.
// ----------------------------------------------------------------------------
`default_nettype none

package nsht_pkg;

  localparam int COORD_W = 16;   // signed Q12.4 coordinate
  localparam int TOL_W   = 16;   // tolerance register
  localparam int IDX_W   = 10;   // reported segment index
  localparam int DIST_W  = 33;   // reported squared distance
  localparam int BEST_W  = 34;   // running limit / best distance
  localparam int OP_W    = 18;   // multiplier operand, signed
  localparam int PROD_W  = 2 * OP_W;
  localparam int T_W     = 17;   // projection factor, Q1.16
  localparam int FRAC_W  = 16;   // fraction bits of the projection factor

  localparam int MAX_SEGMENTS_DEF = 1024;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(80);

endpackage

`default_nettype wire

// File: sv/nearest_segment_hit_test.sv
// ----------------------------------------------------------------------------
// nearest_segment_hit_test
// Finds the segment nearest a query point within a tolerance radius.
// ----------------------------------------------------------------------------
// A query is a run of segment requests, each carrying the query point, the
// segment endpoints (all signed Q12.4) and a last-segment flag. For every
// segment the block computes the squared point-to-segment distance (to the
// start when the projection falls before it or the segment has zero length,
// to the end when it falls past it, otherwise to the rounded projection
// point) and keeps the smallest one strictly below tolerance^2, with its
// stream position. The request that carries last_segment produces one result
// (hit, index, squared distance in Q24.8), after which the running state is
// cleared. Segments at position MAX_SEGMENTS and beyond are not evaluated,
// but their last flag still closes the query. A single 18x18 signed
// multiplier (multiply, then accumulate) and a radix-2 restoring divider
// carry all products and the quotient. A segment whose projection lands
// on an endpoint needs the dot and length products, a check and the
// distance products; one that needs the projection factor also runs the
// divider and two projection products; the first segment of a query also
// forms tolerance^2; the final segment hands off its result. in_ready is
// low while a segment is being worked on. A finished result sits in an output
// register, so the next query may start while it waits to be taken.
// A tolerance write with no segment seen yet in the current query takes
// effect for that query; otherwise it applies from the next query on.
// cfg_ready follows in_ready, so a write never lands on a segment in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_segment_hit_test #(
  parameter int MAX_SEGMENTS = nsht_pkg::MAX_SEGMENTS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,

  // configuration write (tolerance)
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire        [nsht_pkg::TOL_W-1:0]     cfg_tolerance,

  // segment requests
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire signed [nsht_pkg::COORD_W-1:0]   in_point_x,
  input  wire signed [nsht_pkg::COORD_W-1:0]   in_point_y,
  input  wire signed [nsht_pkg::COORD_W-1:0]   in_start_x,
  input  wire signed [nsht_pkg::COORD_W-1:0]   in_start_y,
  input  wire signed [nsht_pkg::COORD_W-1:0]   in_end_x,
  input  wire signed [nsht_pkg::COORD_W-1:0]   in_end_y,
  input  wire                                  in_last_segment,

  // query results
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic                                 out_hit,
  output logic       [nsht_pkg::IDX_W-1:0]     out_nearest_index,
  output logic       [nsht_pkg::DIST_W-1:0]    out_nearest_dist_sq
);

  localparam int OP_W   = nsht_pkg::OP_W;
  localparam int PROD_W = nsht_pkg::PROD_W;
  localparam int T_W    = nsht_pkg::T_W;
  localparam int FRAC_W = nsht_pkg::FRAC_W;
  localparam int BEST_W = nsht_pkg::BEST_W;
  localparam int IDX_W  = nsht_pkg::IDX_W;
  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int DCNT_W = $clog2(T_W);
  localparam int RND_W  = OP_W + 2;   // rounded projection offset

  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_SEGMENTS);
  localparam logic [DCNT_W-1:0] DIV_LAST  = DCNT_W'(T_W - 1);
  localparam logic signed [PROD_W-1:0] HALF_LSB =
    PROD_W'(64'd1 << (FRAC_W - 1));

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL   = 7'b0000010,
    ST_ACC   = 7'b0000100,
    ST_CHECK = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_UPD   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  // which product the shared multiplier is working on
  typedef enum logic [3:0] {
    STP_TOL    = 4'd0,
    STP_DOT_X  = 4'd1,
    STP_DOT_Y  = 4'd2,
    STP_LEN_X  = 4'd3,
    STP_LEN_Y  = 4'd4,
    STP_PROJ_X = 4'd5,
    STP_PROJ_Y = 4'd6,
    STP_DIST_X = 4'd7,
    STP_DIST_Y = 4'd8
  } step_t;

  state_t state_r, state_nxt;
  step_t  step_r;

  logic [nsht_pkg::TOL_W-1:0] tol_r;
  logic                       reload_r;     // limit must be reloaded with tol^2

  // per-segment operands
  logic signed [OP_W-1:0] abx_r, aby_r, apx_r, apy_r, bpx_r, bpy_r;
  logic signed [OP_W-1:0] dx_r, dy_r;
  logic                   last_r;

  // shared multiplier
  logic signed [OP_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r;

  // accumulators
  logic signed [PROD_W-1:0] dot_r, len_r, dist_r;

  // divider
  logic [PROD_W-1:0] rem_r, trial;
  logic              ge;
  logic [T_W-1:0]    t_r;
  logic [DCNT_W-1:0] dcnt_r;

  // projection rounding
  logic signed [PROD_W-1:0] rnd_full;
  logic signed [RND_W-1:0]  rnd;
  logic signed [RND_W-1:0]  proj_d;

  // running query state
  logic [BEST_W-1:0] best_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic              found_r;
  logic [CNT_W-1:0]  cnt_r;

  logic in_acc;
  logic in_eval;
  logic better;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign in_eval   = (cnt_r < CNT_MAX);
  assign better    = (dist_r < $signed({2'b00, best_r}));

  // ---- shared multiplier operand select ----
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_r)
      STP_TOL: begin
        mul_a = $signed(OP_W'(tol_r));
        mul_b = $signed(OP_W'(tol_r));
      end
      STP_DOT_X: begin
        mul_a = abx_r;
        mul_b = apx_r;
      end
      STP_DOT_Y: begin
        mul_a = aby_r;
        mul_b = apy_r;
      end
      STP_LEN_X: begin
        mul_a = abx_r;
        mul_b = abx_r;
      end
      STP_LEN_Y: begin
        mul_a = aby_r;
        mul_b = aby_r;
      end
      STP_PROJ_X: begin
        mul_a = abx_r;
        mul_b = $signed(OP_W'(t_r));
      end
      STP_PROJ_Y: begin
        mul_a = aby_r;
        mul_b = $signed(OP_W'(t_r));
      end
      STP_DIST_X: begin
        mul_a = dx_r;
        mul_b = dx_r;
      end
      STP_DIST_Y: begin
        mul_a = dy_r;
        mul_b = dy_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // floor((d*t + half) / 2^16); arithmetic shift gives floor for both signs
  assign rnd_full = (prod_r + HALF_LSB) >>> FRAC_W;
  assign rnd      = rnd_full[RND_W-1:0];
  assign proj_d   = RND_W'(step_r == STP_PROJ_X ? apx_r : apy_r) - rnd;

  // restoring divide step: t = floor(dot * 2^16 / len), 17 quotient bits
  assign trial = (dcnt_r == '0) ? rem_r : {rem_r[PROD_W-2:0], 1'b0};
  assign ge    = (trial >= len_r);

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_eval) begin
            state_nxt = ST_MUL;
          end else if (in_last_segment) begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (step_r == STP_LEN_Y) begin
          state_nxt = ST_CHECK;
        end else if (step_r == STP_DIST_Y) begin
          state_nxt = ST_UPD;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_CHECK: begin
        if (len_r == '0 || dot_r <= 0 || dot_r > len_r) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (dcnt_r == DIV_LAST) begin
          state_nxt = ST_MUL;
        end
      end
      ST_UPD: begin
        state_nxt = last_r ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---- datapath ----
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc) begin
      abx_r  <= OP_W'(in_end_x)   - OP_W'(in_start_x);
      aby_r  <= OP_W'(in_end_y)   - OP_W'(in_start_y);
      apx_r  <= OP_W'(in_point_x) - OP_W'(in_start_x);
      apy_r  <= OP_W'(in_point_y) - OP_W'(in_start_y);
      bpx_r  <= OP_W'(in_point_x) - OP_W'(in_end_x);
      bpy_r  <= OP_W'(in_point_y) - OP_W'(in_end_y);
      last_r <= in_last_segment;
      step_r <= reload_r ? STP_TOL : STP_DOT_X;
    end

    if (state_r == ST_MUL) begin
      prod_r <= mul_a * mul_b;
    end

    if (state_r == ST_ACC) begin
      case (step_r)
        STP_DOT_X:  dot_r  <= prod_r;
        STP_DOT_Y:  dot_r  <= dot_r + prod_r;
        STP_LEN_X:  len_r  <= prod_r;
        STP_LEN_Y:  len_r  <= len_r + prod_r;
        STP_PROJ_X: dx_r   <= proj_d[OP_W-1:0];
        STP_PROJ_Y: dy_r   <= proj_d[OP_W-1:0];
        STP_DIST_X: dist_r <= prod_r;
        STP_DIST_Y: dist_r <= dist_r + prod_r;
        default:    ;
      endcase
      if (step_r != STP_DIST_Y && step_r != STP_LEN_Y) begin
        step_r <= step_t'(step_r + 4'd1);
      end
    end

    if (state_r == ST_CHECK) begin
      rem_r  <= dot_r;
      dcnt_r <= '0;
      if (len_r == '0 || dot_r <= 0) begin
        // before the start, or degenerate segment
        dx_r   <= apx_r;
        dy_r   <= apy_r;
        step_r <= STP_DIST_X;
      end else if (dot_r > len_r) begin
        // past the end
        dx_r   <= bpx_r;
        dy_r   <= bpy_r;
        step_r <= STP_DIST_X;
      end else begin
        step_r <= STP_PROJ_X;
      end
    end

    if (state_r == ST_DIV) begin
      rem_r  <= ge ? trial - len_r : trial;
      t_r    <= {t_r[T_W-2:0], ge};
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
  end

  // ---- tolerance, running query state, result register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r      <= nsht_pkg::TOL_RESET;
      reload_r   <= 1'b1;
      found_r    <= 1'b0;
      best_idx_r <= '0;
      cnt_r      <= '0;
      out_valid  <= 1'b0;
    end else begin
      // a new result loaded in ST_OUT replaces the one taken
      if (out_valid && out_ready && state_r != ST_OUT) begin
        out_valid <= 1'b0;
      end

      if (state_r == ST_ACC && step_r == STP_TOL) begin
        best_r   <= prod_r[BEST_W-1:0];
        reload_r <= 1'b0;
      end

      if (state_r == ST_UPD) begin
        if (better) begin
          best_r     <= dist_r[BEST_W-1:0];
          best_idx_r <= IDX_W'(cnt_r);
          found_r    <= 1'b1;
        end
        cnt_r <= cnt_r + CNT_W'(1);
      end

      if (state_r == ST_OUT && (!out_valid || out_ready)) begin
        out_valid           <= 1'b1;
        out_hit             <= found_r;
        out_nearest_index   <= best_idx_r;
        out_nearest_dist_sq <= found_r ? best_r[nsht_pkg::DIST_W-1:0] : '0;
        found_r             <= 1'b0;
        best_idx_r          <= '0;
        cnt_r               <= '0;
        reload_r            <= 1'b1;
      end

      // a write before the first segment of a query re-arms the limit
      if (cfg_valid && cfg_ready) begin
        tol_r <= cfg_tolerance;
        if (cnt_r == '0) begin
          reload_r <= 1'b1;
        end
      end
    end
  end

  // ---- assertions ----
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("segment count past limit");

  a_idx_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !found_r |-> best_idx_r == '0)
    else $error("index set without a hit");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> len_r > 0)
    else $error("divide by zero length");

  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && dcnt_r == DIV_LAST) |=> t_r <= T_W'(1 << FRAC_W))
    else $error("projection factor out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_valid && !out_ready) |=> state_r == ST_OUT)
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire

// File: sim/nsht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsht_checker
// Watches the tolerance, segment and result channels of the nearest segment
// hit test, tracks the running query on its own, and compares each result.
// ----------------------------------------------------------------------------
module nsht_checker #(
  parameter int MAX_SEGMENTS = nsht_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic        [nsht_pkg::TOL_W-1:0]    cfg_tolerance,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic signed [nsht_pkg::COORD_W-1:0]  in_point_x,
  input  logic signed [nsht_pkg::COORD_W-1:0]  in_point_y,
  input  logic signed [nsht_pkg::COORD_W-1:0]  in_start_x,
  input  logic signed [nsht_pkg::COORD_W-1:0]  in_start_y,
  input  logic signed [nsht_pkg::COORD_W-1:0]  in_end_x,
  input  logic signed [nsht_pkg::COORD_W-1:0]  in_end_y,
  input  logic                                 in_last_segment,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic                                 out_hit,
  input  logic        [nsht_pkg::IDX_W-1:0]    out_nearest_index,
  input  logic        [nsht_pkg::DIST_W-1:0]   out_nearest_dist_sq,
  output int                                   mismatch_count,
  output int                                   reports_due
);
  localparam int IDX_W  = nsht_pkg::IDX_W;
  localparam int DIST_W = nsht_pkg::DIST_W;
  localparam int TOL_W  = nsht_pkg::TOL_W;
  localparam int BEST_W = nsht_pkg::BEST_W;
  localparam int FRAC_W = nsht_pkg::FRAC_W;
  localparam logic [TOL_W-1:0] TOL_RESET = nsht_pkg::TOL_RESET;

  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] dist_sq;
  } hit_report_t;

  hit_report_t       query_reports_q[$];
  logic [TOL_W-1:0]  tolerance;
  logic [BEST_W-1:0] best_dist_sq;
  int                best_index;
  logic              found;
  int                seg_count;
  int                errors = 0;

  function automatic logic [BEST_W-1:0] tolerance_sq();
    return BEST_W'(tolerance) * BEST_W'(tolerance);
  endfunction

  function automatic void clear_query();
    best_dist_sq = tolerance_sq();
    best_index   = 0;
    found        = 1'b0;
    seg_count    = 0;
  endfunction

  // squared distance from P to segment A-B, Q24.8
  function automatic longint segment_dist_sq(input longint px, input longint py,
                                             input longint ax, input longint ay,
                                             input longint bx, input longint by);
    longint abx, aby, apx, apy, dot, len2, t, qx, qy;
    abx  = bx - ax;
    aby  = by - ay;
    apx  = px - ax;
    apy  = py - ay;
    dot  = abx * apx + aby * apy;
    len2 = abx * abx + aby * aby;
    // zero length, or projection at or before the start
    if (len2 == 0 || dot <= 0)
      return apx * apx + apy * apy;
    if (dot > len2)
      return (px - bx) * (px - bx) + (py - by) * (py - by);
    t  = (dot * 65536) / len2;
    // arithmetic shift floors, so this is round half up
    qx = ax + ((abx * t + 32768) >>> FRAC_W);
    qy = ay + ((aby * t + 32768) >>> FRAC_W);
    return (px - qx) * (px - qx) + (py - qy) * (py - qy);
  endfunction

  task automatic note_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin : watch
    hit_report_t want;
    longint      d;
    if (!rst_n) begin
      tolerance = TOL_RESET;
      clear_query();
      query_reports_q.delete();
    end else begin
      // results first: one taken now was closed by an earlier request
      if (out_valid && out_ready) begin
        if (query_reports_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result hit %0b index %0d dist %0d",
                                  out_hit, out_nearest_index, out_nearest_dist_sq));
        end else begin
          want = query_reports_q.pop_front();
          if (out_hit !== want.hit)
            note_mismatch($sformatf("hit %0b, want %0b", out_hit, want.hit));
          if (out_nearest_index !== want.index)
            note_mismatch($sformatf("nearest_index %0d, want %0d",
                                    out_nearest_index, want.index));
          if (out_nearest_dist_sq !== want.dist_sq)
            note_mismatch($sformatf("nearest_dist_sq %0d, want %0d",
                                    out_nearest_dist_sq, want.dist_sq));
        end
      end
      if (cfg_valid && cfg_ready) begin
        tolerance = cfg_tolerance;
        if (seg_count == 0)
          best_dist_sq = tolerance_sq();
      end
      if (in_valid && in_ready) begin
        if (seg_count < MAX_SEGMENTS) begin
          d = segment_dist_sq(longint'(in_point_x), longint'(in_point_y),
                              longint'(in_start_x), longint'(in_start_y),
                              longint'(in_end_x), longint'(in_end_y));
          if (BEST_W'(d) < best_dist_sq) begin
            best_dist_sq = BEST_W'(d);
            best_index   = seg_count;
            found        = 1'b1;
          end
          seg_count++;
        end
        if (in_last_segment) begin
          want.hit     = found;
          want.index   = found ? IDX_W'(best_index) : '0;
          want.dist_sq = found ? best_dist_sq[DIST_W-1:0] : '0;
          query_reports_q.push_back(want);
          clear_query();
        end
      end
    end
    mismatch_count <= errors;
    reports_due    <= query_reports_q.size();
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives segment requests and tolerance writes into the nearest segment hit
// test, stalls the result side at random, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
  localparam int COORD_W          = nsht_pkg::COORD_W;
  localparam int TOL_W            = nsht_pkg::TOL_W;
  localparam int IDX_W            = nsht_pkg::IDX_W;
  localparam int DIST_W           = nsht_pkg::DIST_W;
  localparam int MAX_SEGMENTS_DEF = nsht_pkg::MAX_SEGMENTS_DEF;
  localparam logic [TOL_W-1:0] TOL_RESET = nsht_pkg::TOL_RESET;

  // one segment request as seen on the input channel
  typedef struct {
    logic signed [COORD_W-1:0] px, py, ax, ay, bx, by;
    logic                      last;
  } segment_req_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic        [TOL_W-1:0]    cfg_tolerance;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [COORD_W-1:0]  in_point_x;
  logic signed [COORD_W-1:0]  in_point_y;
  logic signed [COORD_W-1:0]  in_start_x;
  logic signed [COORD_W-1:0]  in_start_y;
  logic signed [COORD_W-1:0]  in_end_x;
  logic signed [COORD_W-1:0]  in_end_y;
  logic                       in_last_segment;
  logic                       out_valid;
  logic                       out_ready;
  logic                       out_hit;
  logic        [IDX_W-1:0]    out_nearest_index;
  logic        [DIST_W-1:0]   out_nearest_dist_sq;

  int mismatches;
  int reports_due;
  bit no_idle;   // set for stretches where neither side idles

  always #5 clk = ~clk;

  nearest_segment_hit_test #(
    .MAX_SEGMENTS (MAX_SEGMENTS_DEF)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_tolerance       (cfg_tolerance),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_point_x          (in_point_x),
    .in_point_y          (in_point_y),
    .in_start_x          (in_start_x),
    .in_start_y          (in_start_y),
    .in_end_x            (in_end_x),
    .in_end_y            (in_end_y),
    .in_last_segment     (in_last_segment),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_hit             (out_hit),
    .out_nearest_index   (out_nearest_index),
    .out_nearest_dist_sq (out_nearest_dist_sq)
  );

  nsht_checker #(
    .MAX_SEGMENTS (MAX_SEGMENTS_DEF)
  ) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_tolerance       (cfg_tolerance),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_point_x          (in_point_x),
    .in_point_y          (in_point_y),
    .in_start_x          (in_start_x),
    .in_start_y          (in_start_y),
    .in_end_x            (in_end_x),
    .in_end_y            (in_end_y),
    .in_last_segment     (in_last_segment),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_hit             (out_hit),
    .out_nearest_index   (out_nearest_index),
    .out_nearest_dist_sq (out_nearest_dist_sq),
    .mismatch_count      (mismatches),
    .reports_due         (reports_due)
  );

  // --------------------------------------------------------------------------
  // Request helpers
  // --------------------------------------------------------------------------

  function automatic segment_req_t seg(input int px, input int py,
                                       input int ax, input int ay,
                                       input int bx, input int by,
                                       input logic last);
    segment_req_t s;
    s.px   = COORD_W'(px);
    s.py   = COORD_W'(py);
    s.ax   = COORD_W'(ax);
    s.ay   = COORD_W'(ay);
    s.bx   = COORD_W'(bx);
    s.by   = COORD_W'(by);
    s.last = last;
    return s;
  endfunction

  // saturate to the Q12.4 range so a nearby point stays nearby
  function automatic logic signed [COORD_W-1:0] clamp_coord(input int v);
    if (v > 32767)
      return COORD_W'(32767);
    if (v < -32768)
      return COORD_W'(-32768);
    return COORD_W'(v);
  endfunction

  function automatic int spread(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic signed [COORD_W-1:0] rail_value();
    case ($urandom_range(0, 4))
      0:       return COORD_W'(-32768);
      1:       return COORD_W'(32767);
      2:       return COORD_W'(-1);
      3:       return COORD_W'(1);
      default: return '0;
    endcase
  endfunction

  // Mostly short segments with the point placed around them, so that hits,
  // misses, both end regions and the interior all come up. A tenth is raw
  // noise over the full range and a tenth sits on the coordinate rails.
  function automatic segment_req_t random_segment(input logic last);
    segment_req_t s;
    int mode, cx, cy, span, ax, ay, bx, by, f, off;
    mode   = $urandom_range(0, 9);
    s.last = last;
    if (mode == 0) begin
      s.px = COORD_W'($urandom());
      s.py = COORD_W'($urandom());
      s.ax = COORD_W'($urandom());
      s.ay = COORD_W'($urandom());
      s.bx = COORD_W'($urandom());
      s.by = COORD_W'($urandom());
    end else if (mode == 1) begin
      s.px = rail_value();
      s.py = rail_value();
      s.ax = rail_value();
      s.ay = rail_value();
      s.bx = rail_value();
      s.by = rail_value();
    end else begin
      cx = spread(30000);
      cy = spread(30000);
      case ($urandom_range(0, 3))
        0:       span = 8;
        1:       span = 64;
        2:       span = 512;
        default: span = 4096;
      endcase
      ax = cx + spread(span);
      ay = cy + spread(span);
      if ($urandom_range(0, 7) == 0) begin
        bx = ax;   // zero length
        by = ay;
      end else begin
        bx = cx + spread(span);
        by = cy + spread(span);
      end
      // position along the segment in 1/1024, overshooting both ends
      f    = int'($urandom_range(0, 1536)) - 256;
      off  = $urandom_range(0, 120);
      s.px = clamp_coord(ax + (bx - ax) * f / 1024 + spread(off));
      s.py = clamp_coord(ay + (by - ay) * f / 1024 + spread(off));
      s.ax = clamp_coord(ax);
      s.ay = clamp_coord(ay);
      s.bx = clamp_coord(bx);
      s.by = clamp_coord(by);
    end
    return s;
  endfunction

  // Hold off a random number of cycles, then present the request and keep it
  // until it is taken. Returns at the accepting edge.
  task automatic send_segment(input segment_req_t s);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_point_x      <= s.px;
    in_point_y      <= s.py;
    in_start_x      <= s.ax;
    in_start_y      <= s.ay;
    in_end_x        <= s.bx;
    in_end_y        <= s.by;
    in_last_segment <= s.last;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Tolerance is only written with the block idle: all results drained, and
  // enough cycles for a segment that closes no query to finish.
  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_valid     <= 1'b1;
    cfg_tolerance <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall before each result, none in quiet stretches
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and verdict
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int               n_sent;
    int               left_in_query;
    int               phase;
    logic [TOL_W-1:0] tol;

    rst_n           <= 1'b0;
    cfg_valid       <= 1'b0;
    cfg_tolerance   <= '0;
    in_valid        <= 1'b0;
    in_point_x      <= '0;
    in_point_y      <= '0;
    in_start_x      <= '0;
    in_start_y      <= '0;
    in_end_x        <= '0;
    in_end_y        <= '0;
    in_last_segment <= 1'b0;
    no_idle          = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset tolerance (80): interior, before start, past end, projection
    // landing exactly on the end, zero length, and a tie between two segments
    // that an earlier, closer segment still beats.
    send_segment(seg(800, 40, 0, 0, 1600, 0, 1'b0));
    send_segment(seg(-30, 0, 0, 0, 100, 0, 1'b0));
    send_segment(seg(130, 10, 0, 0, 100, 0, 1'b0));
    send_segment(seg(100, 50, 0, 0, 100, 0, 1'b0));
    send_segment(seg(3, 0, 0, 0, 7, 3, 1'b0));
    send_segment(seg(5, 5, 7, 7, 7, 7, 1'b0));
    send_segment(seg(5, 5, 7, 7, 7, 7, 1'b1));
    // query with no hit
    send_segment(seg(1000, 1000, 0, 0, 10, 0, 1'b1));
    // coordinate rails: full-length diagonals, zero distance, max distance
    send_segment(seg(32767, -32768, -32768, -32768, 32767, 32767, 1'b0));
    send_segment(seg(-32768, 32767, 32767, 32767, -32768, -32768, 1'b0));
    send_segment(seg(-32768, -32768, -32768, -32768, -32768, -32768, 1'b0));
    send_segment(seg(32767, 32767, -32768, -32768, -32768, -32768, 1'b1));

    // zero tolerance: even a zero distance is not a hit
    write_tolerance('0);
    send_segment(seg(0, 0, 0, 0, 0, 0, 1'b1));

    // widest tolerance: a distance equal to it misses, one just inside hits
    write_tolerance('1);
    send_segment(seg(-32768, 0, 32767, 0, 32767, 0, 1'b0));
    send_segment(seg(-32767, 0, 32767, 0, 32767, 0, 1'b1));

    // Tolerance changed mid-query: the open query keeps the old limit, the
    // next one picks up the new value.
    write_tolerance(TOL_W'(1));
    send_segment(seg(10, 10, 0, 0, 0, 0, 1'b0));
    write_tolerance(TOL_W'(1000));
    send_segment(seg(3, 4, 0, 0, 0, 0, 1'b1));
    send_segment(seg(3, 4, 0, 0, 0, 0, 1'b1));

    // Over-long query: positions past the segment limit carry zero distance
    // but must be ignored; the last flag on one of them still closes it.
    write_tolerance(TOL_RESET);
    no_idle = ($urandom_range(0, 1) == 0);
    for (int i = 0; i < MAX_SEGMENTS_DEF + 6; i++) begin
      if (i < MAX_SEGMENTS_DEF - 1)
        send_segment(random_segment(1'b0));
      else
        send_segment(seg(5, 5, 5, 5, 5, 5, i == MAX_SEGMENTS_DEF + 5));
    end

    // Random phases, each with its own tolerance. Phases end on a request
    // count, so some writes land in the middle of an open query.
    n_sent        = 0;
    left_in_query = 0;
    phase         = 0;
    while (n_sent < 900) begin
      case (phase % 6)
        0:       tol = '0;
        1:       tol = '1;
        2:       tol = TOL_RESET;
        3:       tol = TOL_W'(1);
        4:       tol = TOL_W'($urandom_range(0, 2000));
        default: tol = TOL_W'($urandom());
      endcase
      write_tolerance(tol);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(100, 200)) begin
        if (left_in_query == 0)
          left_in_query = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(1, 8);
        left_in_query--;
        send_segment(random_segment(left_in_query == 0));
        n_sent++;
      end
      phase++;
    end
    if (left_in_query != 0)
      send_segment(random_segment(1'b1));

    // drain, then give a stray result time to show up
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0)
      $display("PASS nearest_segment_hit_test");
    else
      $display("FAIL nearest_segment_hit_test");
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin : watchdog
    #(15_000_000);
    $display("FAIL nearest_segment_hit_test");
    $finish;
  end

endmodule
